[rtl/fpid_pkg.sv]
package fpid_pkg;

  // Field widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned ERR_W     = DATA_W + 1;
  localparam int unsigned DERR_W    = ERR_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  // Default fraction bits of the gains
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Output queue: deep enough to cover the three stages in flight plus the word in hand
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // Reset values of the output limits
  localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = 16'sh8000;

  // Saturation bounds of the integral accumulator
  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7fff_ffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_DRIVE_MAX  = 3'd3,
    CFG_DRIVE_MIN  = 3'd4
  } cfg_reg_e;

endpackage

[rtl/fixed_point_pid_controller.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------
// in       | input     | in_valid_i / in_stall_o    | target_i, sensed_i
// out      | output    | out_valid_o / out_stall_i  | drive_o
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One word in per cycle while in_stall_o is low, one drive word out per word in;
// words pass the error, multiply and term/integral registers, then the output queue.
// The integral add-and-clamp on the accumulator register sets the cycle time.
// Reset clears the integral, the stored error, the pipeline and the queue, and
// loads the default gains and limits. in_stall_o rises when the queue plus the
// words in flight fill the eight-entry output queue; the pipeline itself never stalls.
module fixed_point_pid_controller #(
  parameter int unsigned FRAC_BITS = fpid_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fpid_pkg::DATA_W-1:0]  target_i,
  input  logic signed [fpid_pkg::DATA_W-1:0]  sensed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fpid_pkg::DATA_W-1:0]  drive_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fpid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fpid_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned DW      = fpid_pkg::DATA_W;
  localparam int unsigned PPROD_W = fpid_pkg::GAIN_W + fpid_pkg::ERR_W;
  localparam int unsigned DPROD_W = fpid_pkg::GAIN_W + fpid_pkg::DERR_W;
  localparam int unsigned PT_W    = PPROD_W - FRAC_BITS;
  localparam int unsigned DT_W    = DPROD_W - FRAC_BITS;
  localparam int unsigned ISUM_W  = PPROD_W + 2;
  localparam int unsigned SUM_W   = DT_W + 2;
  localparam int unsigned OCC_W   = fpid_pkg::CNT_W + 1;

  localparam logic signed [ISUM_W-1:0] ISUM_ACC_MAX = ISUM_W'(fpid_pkg::ACC_MAX);
  localparam logic signed [ISUM_W-1:0] ISUM_ACC_MIN = ISUM_W'(fpid_pkg::ACC_MIN);

  // Configuration
  logic signed [fpid_pkg::GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [DW-1:0]               drive_max_q, drive_min_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      drive_max_q  <= fpid_pkg::DRIVE_MAX_RST;
      drive_min_q  <= fpid_pkg::DRIVE_MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (fpid_pkg::cfg_reg_e'(cfg_index_i))
        fpid_pkg::CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
        fpid_pkg::CFG_INTEG_GAIN: integ_gain_q <= cfg_data_i;
        fpid_pkg::CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
        fpid_pkg::CFG_DRIVE_MAX:  drive_max_q  <= cfg_data_i[DW-1:0];
        fpid_pkg::CFG_DRIVE_MIN:  drive_min_q  <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: error and error difference
  logic                                 in_acc;
  logic signed [fpid_pkg::ERR_W-1:0]    err_d, err_q, last_err_q;
  logic signed [fpid_pkg::DERR_W-1:0]   derr_d, derr_q;
  logic                                 v1_q, v2_q, v3_q;

  assign in_acc = in_valid_i && !in_stall_o;
  assign err_d  = fpid_pkg::ERR_W'(target_i) - fpid_pkg::ERR_W'(sensed_i);
  assign derr_d = fpid_pkg::DERR_W'(err_d) - fpid_pkg::DERR_W'(last_err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (in_acc) begin
      last_err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q  <= err_d;
      derr_q <= derr_d;
    end
  end

  // Stage 2: three products
  logic signed [PPROD_W-1:0] p_prod_d, p_prod_q, i_prod_d, i_prod_q;
  logic signed [DPROD_W-1:0] d_prod_d, d_prod_q;

  assign p_prod_d = prop_gain_q * err_q;
  assign i_prod_d = integ_gain_q * err_q;
  assign d_prod_d = deriv_gain_q * derr_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_prod_q <= p_prod_d;
      i_prod_q <= i_prod_d;
      d_prod_q <= d_prod_d;
    end
  end

  // Stage 3: scaled terms and integral update, upper bound tested first
  logic signed [PT_W-1:0]          p_term_q;
  logic signed [DT_W-1:0]          d_term_q;
  logic signed [fpid_pkg::ACC_W-1:0] acc_d, acc_q;
  logic signed [ISUM_W-1:0]        isum, ilim_hi, ilim_lo, ilim;

  assign isum    = ISUM_W'(acc_q) + ISUM_W'(i_prod_q);
  assign ilim_hi = ISUM_W'(drive_max_q) <<< FRAC_BITS;
  assign ilim_lo = ISUM_W'(drive_min_q) <<< FRAC_BITS;

  always_comb begin
    priority if (isum > ilim_hi) begin
      ilim = ilim_hi;
    end else if (isum < ilim_lo) begin
      ilim = ilim_lo;
    end else begin
      ilim = isum;
    end
    priority if (ilim > ISUM_ACC_MAX) begin
      acc_d = fpid_pkg::ACC_MAX;
    end else if (ilim < ISUM_ACC_MIN) begin
      acc_d = fpid_pkg::ACC_MIN;
    end else begin
      acc_d = ilim[fpid_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      p_term_q <= PT_W'(p_prod_q >>> FRAC_BITS);
      d_term_q <= DT_W'(d_prod_q >>> FRAC_BITS);
    end
  end

  // Full-width sum and output clamp
  logic signed [SUM_W-1:0] sum, sum_hi, sum_lo;
  logic signed [DW-1:0]    drive_d;

  assign sum    = SUM_W'(p_term_q) + SUM_W'(acc_q >>> FRAC_BITS) - SUM_W'(d_term_q);
  assign sum_hi = SUM_W'(drive_max_q);
  assign sum_lo = SUM_W'(drive_min_q);

  always_comb begin
    priority if (sum > sum_hi) begin
      drive_d = drive_max_q;
    end else if (sum < sum_lo) begin
      drive_d = drive_min_q;
    end else begin
      drive_d = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Output queue
  logic signed [DW-1:0]         fifo_q [fpid_pkg::FIFO_DEPTH];
  logic [fpid_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [fpid_pkg::CNT_W-1:0]   cnt_q;
  logic [OCC_W-1:0]             occ;
  logic                         push, pop;

  assign push = v3_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= fpid_pkg::PTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= fpid_pkg::PTR_W'(rd_ptr_q + 1'b1);
      end
      priority if (push && !pop) begin
        cnt_q <= fpid_pkg::CNT_W'(cnt_q + 1'b1);
      end else if (pop && !push) begin
        cnt_q <= fpid_pkg::CNT_W'(cnt_q - 1'b1);
      end else begin
        cnt_q <= cnt_q;
      end
    end
  end

  // Hold the input once queued plus in-flight words could fill the queue
  assign occ        = OCC_W'(cnt_q) + OCC_W'(v1_q) + OCC_W'(v2_q) + OCC_W'(v3_q);
  assign in_stall_o = occ >= OCC_W'(fpid_pkg::FIFO_DEPTH);

  assign out_valid_o = cnt_q != '0;
  assign drive_o     = fifo_q[rd_ptr_q];

endmodule
